// ===== design/reed_solomon_parity_encoder_top_defines.svh =====
// assertion macros used by the encoder rtl
`ifndef REED_SOLOMON_PARITY_ENCODER_TOP_DEFINES_SVH
`define REED_SOLOMON_PARITY_ENCODER_TOP_DEFINES_SVH

// clocked check, masked while reset is asserted
`define RSPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define RSPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/rspe_pkg.sv =====
`default_nettype none

package rspe_pkg;

  // number of parity symbols per block
  localparam int PARITY_COUNT = 30;
  localparam int CNT_W = $clog2(PARITY_COUNT);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PARITY_COUNT - 1);

  // field polynomial x^8+x^4+x^3+x^2+1
  localparam logic [8:0] FIELD_POLY = 9'h11d;

  typedef logic [7:0] gf_t;
  typedef logic [PARITY_COUNT-1:0][7:0] parity_vec_t;

  // generator coefficients as logs base alpha, entry i for x^i
  localparam gf_t GEN_LOG [PARITY_COUNT] = '{
    8'hb4, 8'hc0, 8'h28, 8'hee, 8'hd8, 8'hfb, 8'h25, 8'h9c,
    8'h82, 8'he0, 8'hc1, 8'he2, 8'had, 8'h2a, 8'h7d, 8'hde,
    8'h60, 8'hef, 8'h56, 8'h6e, 8'h30, 8'h32, 8'hb6, 8'hb3,
    8'h1f, 8'hd8, 8'h98, 8'h91, 8'had, 8'h29
  };

  // gf(256) multiply, shift and add
  function automatic gf_t gf_mul(input gf_t a, input gf_t b);
    logic [8:0] x;
    gf_t        r;
    x = {1'b0, a};
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        r = r ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ FIELD_POLY;
      end
    end
    return r;
  endfunction

  // alpha^n, square and multiply; only called with constant n
  function automatic gf_t gf_alpha_pow(input gf_t n);
    gf_t result;
    gf_t base;
    result = 8'h01;
    base   = 8'h02;
    for (int i = 0; i < 8; i++) begin
      if (n[i]) begin
        result = gf_mul(result, base);
      end
      base = gf_mul(base, base);
    end
    return result;
  endfunction

  // generator coefficient of x^idx
  function automatic gf_t gen_coef(input int idx);
    return gf_alpha_pow(GEN_LOG[idx]);
  endfunction

endpackage

`default_nettype wire

// ===== design/reed_solomon_parity_encoder_top.sv =====
// Reed-Solomon parity encoder, gf(256), 30 parity symbols per block.
// Input stream: one data byte per transaction on s_axis, tlast marks the
// final byte of a block. Output stream: 30 parity bytes per block on m_axis,
// first register position first, tlast on the thirtieth byte.
// Each accepted byte updates the 30-byte parity register in the same cycle
// through constant gf multipliers, so one byte is taken every cycle unless
// a block-end byte is held off. On a block end the updated parity is copied
// into a 30-byte drain buffer and the parity register clears; the first
// parity byte shows on m_axis in the cycle after the block-end transaction,
// then one byte per cycle while the receiver takes them.
// Data bytes of the next block keep flowing during the drain. A block-end
// byte is held off (s_axis_tready_o low) only while the drain buffer still
// holds bytes other than the one leaving in that cycle.
// When the receiver stalls, the current parity byte holds on m_axis.
// Reset clears the parity register and empties the drain buffer; there is
// no clearing pass, the block is ready right after reset.
`default_nettype none

`include "reed_solomon_parity_encoder_top_defines.svh"

module reed_solomon_parity_encoder_top
  import rspe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic       s_axis_tlast_i,  // block_end
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,  // [7:0] parity_byte
  output logic            m_axis_tlast_o   // parity_last
);

  parity_vec_t      par_q, par_d, par_upd;
  parity_vec_t      drain_q, drain_d;
  logic             drain_valid_q, drain_valid_d;
  logic [CNT_W-1:0] drain_cnt_q, drain_cnt_d;
  logic             in_acc, out_acc, load_ok, load;
  gf_t              fb;

  // handshakes
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;
  assign load_ok = !drain_valid_q || (out_acc && (drain_cnt_q == LAST_IDX));
  assign s_axis_tready_o = !s_axis_tlast_i || load_ok;
  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign load    = in_acc & s_axis_tlast_i;

  // lfsr update with constant gf multipliers
  assign fb = s_axis_tdata_i ^ par_q[0];
  always_comb begin
    for (int k = 0; k < PARITY_COUNT - 1; k++) begin
      par_upd[k] = par_q[k+1] ^ gf_mul(fb, gen_coef(PARITY_COUNT - 1 - k));
    end
    par_upd[PARITY_COUNT-1] = gf_mul(fb, gen_coef(0));
  end

  // parity register next value, cleared after a block end
  always_comb begin
    par_d = par_q;
    if (in_acc) begin
      par_d = s_axis_tlast_i ? '0 : par_upd;
    end
  end

  // drain buffer: load on block end, shift toward head on output transaction
  always_comb begin
    drain_d       = drain_q;
    drain_valid_d = drain_valid_q;
    drain_cnt_d   = drain_cnt_q;
    if (load) begin
      drain_d       = par_upd;
      drain_valid_d = 1'b1;
      drain_cnt_d   = '0;
    end else if (out_acc) begin
      drain_d = {8'h00, drain_q[PARITY_COUNT-1:1]};
      if (drain_cnt_q == LAST_IDX) begin
        drain_valid_d = 1'b0;
        drain_cnt_d   = '0;
      end else begin
        drain_cnt_d = drain_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q         <= '0;
      drain_valid_q <= 1'b0;
      drain_cnt_q   <= '0;
    end else begin
      par_q         <= par_d;
      drain_valid_q <= drain_valid_d;
      drain_cnt_q   <= drain_cnt_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    drain_q <= drain_d;
  end

  assign m_axis_tvalid_o = drain_valid_q;
  assign m_axis_tdata_o  = drain_q[0];
  assign m_axis_tlast_o  = drain_cnt_q == LAST_IDX;

  // checks
  `RSPE_ASSERT(a_block_end_clears, load |=> (par_q == '0), "parity register not cleared")
  `RSPE_ASSERT(a_block_end_starts_drain, load |=> (m_axis_tvalid_o && (drain_cnt_q == '0)),
               "drain did not start after block end")
  `RSPE_ASSERT(a_drain_continues, (out_acc && !m_axis_tlast_o) |=> m_axis_tvalid_o,
               "drain stopped before the last parity byte")
  `RSPE_ASSERT_ALWAYS(a_cnt_range, !rst_ni || (drain_cnt_q <= LAST_IDX),
                      "drain count out of range")

endmodule

`default_nettype wire
